// ===== src/glyph_bitmap_run_rectangles_assert.svh =====
// Assertion macros shared by the glyph run rectangle modules.
// Each macro expects clk and rst in the scope of the module that uses it.
`ifndef GLYPH_BITMAP_RUN_RECTANGLES_ASSERT_SVH
`define GLYPH_BITMAP_RUN_RECTANGLES_ASSERT_SVH
`ifndef SYNTHESIS
`define GBRR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define GBRR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GBRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GBRR_ASSERT_ALWAYS(lbl, expr, msg)
`define GBRR_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define GBRR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/gbrr_pkg.sv =====
package gbrr_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 64;
  localparam int MAX_SCALE         = 8;

  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 11;
  localparam int RECT_W_W   = 10;
  localparam int SCALE_W    = 4;
  localparam int ROWW_W     = 7;
  localparam int COLOR_W    = 16;
  localparam int ROW_IDX_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_H    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_V    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0]  bitmap_byte;
    logic               glyph_start;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  rect_x;
    logic [COORD_W-1:0]  rect_y;
    logic [RECT_W_W-1:0] rect_w;
    logic [SCALE_W-1:0]  rect_h;
    logic [COLOR_W-1:0]  rect_color;
    logic                last_rect;
  } out_item_t;

  typedef struct packed {
    logic [ROWW_W-1:0]  row_width;
    logic [SCALE_W-1:0] scale_h;
    logic [SCALE_W-1:0] scale_v;
    logic               invert;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic bit_step;
    logic scan_step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic row_done;
    logic bit_last;
    logic bits_empty;
    logic scan_last;
    logic scan_emit;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    if (v == '0) begin
      r = SCALE_W'(1);
    end else if ({1'b0, v} > (SCALE_W+1)'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/gbrr_cfg.sv =====
module gbrr_cfg
  import gbrr_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [ROWW_W-1:0]  row_width;
  logic [SCALE_W-1:0] scale_h;
  logic [SCALE_W-1:0] scale_v;
  logic               invert;
  logic [COLOR_W-1:0] color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROWW_W'(8);
      scale_h   <= SCALE_W'(1);
      scale_v   <= SCALE_W'(1);
      invert    <= 1'b0;
      color     <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_WIDTH:  row_width <= cfg_data[ROWW_W-1:0];
        CFG_SCALE_H:    scale_h   <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_V:    scale_v   <= cfg_data[SCALE_W-1:0];
        CFG_INVERT:     invert    <= cfg_data[0];
        CFG_FILL_COLOR: color     <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg = '0;
    if (row_width == '0) begin
      cfg.row_width = ROWW_W'(1);
    end else if (row_width > ROWW_W'(MAX_ROW_WIDTH)) begin
      cfg.row_width = ROWW_W'(MAX_ROW_WIDTH);
    end else begin
      cfg.row_width = row_width;
    end
    cfg.scale_h = clamp_scale(scale_h);
    cfg.scale_v = clamp_scale(scale_v);
    cfg.invert  = invert;
    cfg.color   = color;
  end

endmodule

// ===== src/gbrr_dp.sv =====
`include "glyph_bitmap_run_rectangles_assert.svh"
module gbrr_dp
  import gbrr_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  in_item_t   in_data,
  input  logic       out_ready,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int IDX_W = $clog2(MAX_ROW_WIDTH);
  localparam int CNT_W = $clog2(MAX_ROW_WIDTH + 1);

  logic [BYTE_W-1:0]        pix_byte;
  logic [3:0]               bit_cnt;
  logic [CNT_W-1:0]         column_pos;
  logic [ROW_IDX_W-1:0]     row_index;
  logic [COORD_W-1:0]       base_x;
  logic [COORD_W-1:0]       base_y;
  logic [MAX_ROW_WIDTH-1:0] row_bits;
  logic [MAX_ROW_WIDTH-1:0] row_next;
  logic [MAX_ROW_WIDTH-1:0] scan_sh;
  logic [IDX_W-1:0]         scan_idx;
  logic                     in_run;
  logic [IDX_W-1:0]         run_start;
  out_item_t                pend;
  logic                     pend_valid;

  logic [CNT_W-1:0] width_eff;
  logic [CNT_W-1:0] col_inc;
  logic             row_done;
  logic             pix;
  logic             scan_last;
  logic             scan_emit;
  logic [IDX_W-1:0] start_eff;
  logic [CNT_W-1:0] run_len;
  logic [12:0]      x_full;
  logic [12:0]      y_full;
  logic [11:0]      w_full;
  out_item_t        rect_new;
  out_item_t        out_next;
  logic             out_free;
  logic             out_load;

  assign width_eff = cfg.row_width[CNT_W-1:0];
  assign col_inc   = column_pos + CNT_W'(1);
  assign row_done  = col_inc >= width_eff;

  always_comb begin
    row_next = row_bits;
    row_next[column_pos[IDX_W-1:0]] = pix_byte[BYTE_W-1];
  end

  assign pix       = scan_sh[0];
  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == width_eff;
  assign scan_emit = pix && (scan_last || !scan_sh[1]);
  assign start_eff = in_run ? run_start : scan_idx;
  assign run_len   = CNT_W'(scan_idx) - CNT_W'(start_eff) + CNT_W'(1);

  assign x_full = 13'(base_x) + 13'(start_eff) * 13'(cfg.scale_h);
  assign y_full = 13'(base_y) + 13'(row_index) * 13'(cfg.scale_v);
  assign w_full = 12'(run_len) * 12'(cfg.scale_h);

  always_comb begin
    rect_new            = '0;
    rect_new.rect_x     = (x_full > 13'd2047) ? '1 : x_full[COORD_W-1:0];
    rect_new.rect_y     = (y_full > 13'd2047) ? '1 : y_full[COORD_W-1:0];
    rect_new.rect_w     = (w_full > 12'd1023) ? '1 : w_full[RECT_W_W-1:0];
    rect_new.rect_h     = cfg.scale_v;
    rect_new.rect_color = cfg.color;
    rect_new.last_rect  = 1'b0;
  end

  always_comb begin
    out_next           = pend;
    out_next.last_rect = cmd.flush;
  end

  assign out_free = !out_valid || out_ready;
  assign out_load = (cmd.scan_step && scan_emit && pend_valid) || cmd.flush;

  always_comb begin
    status            = '0;
    status.row_done   = row_done;
    status.bit_last   = bit_cnt == 4'd1;
    status.bits_empty = bit_cnt == 4'd0;
    status.scan_last  = scan_last;
    status.scan_emit  = scan_emit;
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt    <= '0;
      column_pos <= '0;
      row_index  <= '0;
      base_x     <= '0;
      base_y     <= '0;
      scan_idx   <= '0;
      in_run     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        bit_cnt <= 4'd8;
        if (in_data.glyph_start) begin
          base_x     <= in_data.origin_x;
          base_y     <= in_data.origin_y;
          column_pos <= '0;
          row_index  <= '0;
        end
      end
      if (cmd.bit_step) begin
        bit_cnt    <= bit_cnt - 4'd1;
        column_pos <= row_done ? '0 : col_inc;
        if (row_done) begin
          scan_idx <= '0;
          in_run   <= 1'b0;
        end
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
        in_run   <= pix && !scan_emit;
        if (scan_last && row_index != '1) begin
          row_index <= row_index + ROW_IDX_W'(1);
        end
      end
      if (cmd.scan_step && scan_emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_byte <= cfg.invert ? ~in_data.bitmap_byte : in_data.bitmap_byte;
    end
    if (cmd.bit_step) begin
      pix_byte <= {pix_byte[BYTE_W-2:0], 1'b0};
      row_bits <= row_next;
      if (row_done) begin
        scan_sh <= row_next;
      end
    end
    if (cmd.scan_step) begin
      scan_sh <= scan_sh >> 1;
      if (pix && !in_run) begin
        run_start <= scan_idx;
      end
      if (scan_emit) begin
        pend <= rect_new;
      end
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  `GBRR_ASSERT_ALWAYS(a_col_in_row, column_pos < CNT_W'(MAX_ROW_WIDTH), "column past row buffer")
  `GBRR_ASSERT_IMPLIES(a_out_no_overwrite, out_load, out_free, "output item overwritten")
  `GBRR_ASSERT_IMPLIES(a_scan_in_row, cmd.scan_step, CNT_W'(scan_idx) < width_eff, "scan past row end")

endmodule

// ===== src/gbrr_ctrl.sv =====
`include "glyph_bitmap_run_rectangles_assert.svh"
module gbrr_ctrl
  import gbrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   advance;

  assign advance = !(status.scan_emit && status.pend_valid && !status.out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        if (status.row_done) begin
          state_next = ST_SCAN;
        end else if (status.bit_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (advance && status.scan_last) begin
          state_next = status.bits_empty ? ST_FLUSH : ST_BIT;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_BIT:   cmd.bit_step = 1'b1;
      ST_SCAN:  cmd.scan_step = advance;
      ST_FLUSH: cmd.flush = status.pend_valid && status.out_free;
      default: ;
    endcase
  end

  `GBRR_ASSERT_IMPLIES(a_idle_no_pending, state == ST_IDLE, !status.pend_valid, "pending rect at item accept")
  `GBRR_ASSERT_NEXT(a_flush_ends_item, cmd.flush, state == ST_IDLE, "flush did not end item")

endmodule

// ===== src/glyph_bitmap_run_rectangles.sv =====
// Each item is accepted, its eight pixels are shifted into the row buffer, every row it
// completes is scanned pixel by pixel for runs, and a handover ends it; a new item is
// taken only once the last is through. Output stalls hold the scan and the handover.
// The shared run scanner takes one pixel a cycle while the output does not stall it.
// Synchronous active-high reset clears counters, origin and handshakes and
// restores register defaults; the row buffer is not cleared.
module glyph_bitmap_run_rectangles
  import gbrr_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  gbrr_cfg #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gbrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbrr_dp #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/glyph_bitmap_run_rectangles_test.sv =====
module glyph_bitmap_run_rectangles_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gbrr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_RECTS     = 32;
  localparam int unsigned COORD_LIMIT   = 2047;
  localparam int unsigned WIDTH_LIMIT   = 1023;
  localparam int unsigned ROW_LIMIT     = 255;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  class rect_scoreboard;
    bit                 pixels [MAX_ROW_WIDTH_DEF];
    int unsigned        column, row, base_x, base_y;
    logic [ROWW_W-1:0]  row_width;
    logic [SCALE_W-1:0] scale_h, scale_v;
    logic               invert;
    logic [COLOR_W-1:0] color;
    out_item_t          rects_due[$];
    int unsigned        errors;

    function new();
      column    = 0;
      row       = 0;
      base_x    = 0;
      base_y    = 0;
      row_width = 7'd8;
      scale_h   = 4'd1;
      scale_v   = 4'd1;
      invert    = 1'b0;
      color     = 16'hFFFF;
      errors    = 0;
    endfunction

    function int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROW_WIDTH:  row_width = data[ROWW_W-1:0];
        CFG_SCALE_H:    scale_h = data[SCALE_W-1:0];
        CFG_SCALE_V:    scale_v = data[SCALE_W-1:0];
        CFG_INVERT:     invert = data[0];
        CFG_FILL_COLOR: color = data[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(in_item_t it);
      int unsigned       w, sh, sv, y, col, first, made;
      logic [BYTE_W-1:0] pix;
      bit                run_on;
      out_item_t         r;
      w    = bound(32'(row_width), 1, MAX_ROW_WIDTH_DEF);
      sh   = bound(32'(scale_h), 1, MAX_SCALE);
      sv   = bound(32'(scale_v), 1, MAX_SCALE);
      made = 0;
      if (it.glyph_start) begin
        base_x = 32'(it.origin_x);
        base_y = 32'(it.origin_y);
        column = 0;
        row    = 0;
      end
      pix = invert ? ~it.bitmap_byte : it.bitmap_byte;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        if (column < MAX_ROW_WIDTH_DEF) pixels[column] = pix[i];
        column++;
        if (column >= w) begin
          column = 0;
          y      = bound(base_y + row * sv, 0, COORD_LIMIT);
          col    = 0;
          while (col < w) begin
            first  = col;
            run_on = pixels[col];
            while (col < w && pixels[col] == run_on) col++;
            if (run_on && made < MAX_RECTS) begin
              r.rect_x     = COORD_W'(bound(base_x + first * sh, 0, COORD_LIMIT));
              r.rect_y     = COORD_W'(y);
              r.rect_w     = RECT_W_W'(bound((col - first) * sh, 0, WIDTH_LIMIT));
              r.rect_h     = SCALE_W'(sv);
              r.rect_color = color;
              r.last_rect  = 1'b0;
              rects_due.push_back(r);
              made++;
            end
          end
          if (row < ROW_LIMIT) row++;
        end
      end
      if (made > 0) rects_due[rects_due.size() - 1].last_rect = 1'b1;
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_rect(out_item_t got);
      out_item_t want;
      if (rects_due.size() == 0) begin
        $error("rect with nothing expected: x %0d y %0d w %0d h %0d",
               got.rect_x, got.rect_y, got.rect_w, got.rect_h);
        errors++;
        return;
      end
      want = rects_due.pop_front();
      match_field("rect_x", 32'(want.rect_x), 32'(got.rect_x));
      match_field("rect_y", 32'(want.rect_y), 32'(got.rect_y));
      match_field("rect_w", 32'(want.rect_w), 32'(got.rect_w));
      match_field("rect_h", 32'(want.rect_h), 32'(got.rect_h));
      match_field("rect_color", 32'(want.rect_color), 32'(got.rect_color));
      match_field("last_rect", 32'(want.last_rect), 32'(got.last_rect));
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rect_scoreboard board;
  bit             idle_on      = 1'b0;
  int unsigned    holds_asked  = 0;
  int unsigned    cycles       = 0;

  glyph_bitmap_run_rectangles dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("glyph_bitmap_run_rectangles_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_rect(out_data);
  end

  initial begin : rx_side
    int unsigned burst;
    int unsigned holds_seen;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_seen) begin
        holds_seen = holds_asked;
        out_ready  = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(5, 0) == 0) begin
        burst     = $urandom_range(16, 1);
        out_ready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic in_item_t glyph_byte(bit start, logic [BYTE_W-1:0] b,
                                          int unsigned x, int unsigned y);
    in_item_t it;
    it.bitmap_byte = b;
    it.glyph_start = start;
    it.origin_x    = COORD_W'(x);
    it.origin_y    = COORD_W'(y);
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(3, 0) == 0) return COORD_W'($urandom_range(2047, 1900));
    return COORD_W'($urandom_range(2047, 0));
  endfunction

  task automatic send_byte(input in_item_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(3, 0) == 0) begin
      gap      = $urandom_range(16, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.take_byte(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, cfg_data);
    @(negedge clk);
  endtask

  task automatic program_regs(input int unsigned w, input int unsigned sh,
                              input int unsigned sv, input int unsigned inv,
                              input int unsigned color);
    write_reg(CFG_ROW_WIDTH, w);
    write_reg(CFG_SCALE_H, sh);
    write_reg(CFG_SCALE_V, sv);
    write_reg(CFG_INVERT, inv);
    write_reg(CFG_FILL_COLOR, color);
    cfg_valid = 1'b0;
  endtask

  // let the block finish any row scan that yields nothing
  task automatic drain();
    in_valid = 1'b0;
    while (board.rects_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_glyph(input int unsigned n_bytes, input bit fresh);
    in_item_t it;
    for (int unsigned k = 0; k < n_bytes; k++) begin
      case ($urandom_range(5, 0))
        0: it.bitmap_byte = 8'h00;
        1: it.bitmap_byte = 8'hFF;
        2: it.bitmap_byte = 8'hAA;
        3: it.bitmap_byte = 8'h55;
        default: it.bitmap_byte = BYTE_W'($urandom_range(255, 0));
      endcase
      it.glyph_start = (k == 0) ? fresh : ($urandom_range(15, 0) == 0);
      it.origin_x    = pick_coord();
      it.origin_y    = pick_coord();
      send_byte(it);
    end
  endtask

  task automatic run_phase(input int unsigned target, output int unsigned sent);
    int unsigned w, sh, sv, n;
    bit          fresh;
    case ($urandom_range(7, 0))
      0: w = 1;
      1: w = 64;
      2: w = $urandom_range(127, 0);
      default: w = $urandom_range(16, 1);
    endcase
    sh = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
    sv = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
    program_regs(w, sh, sv, $urandom_range(1, 0), $urandom_range(65535, 0));
    // sometimes carry a partial row over the new width
    fresh = ($urandom_range(3, 0) != 0);
    sent  = 0;
    while (sent < target) begin
      n = $urandom_range(12, 1);
      send_glyph(n, fresh);
      fresh = 1'b1;
      sent += n;
    end
    drain();
  endtask

  initial begin : main_seq
    int unsigned total, sent;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    idle_on = 1'b1;
    send_byte(glyph_byte(1'b1, 8'hFF, 0, 0));
    send_byte(glyph_byte(1'b0, 8'h00, 0, 0));
    send_byte(glyph_byte(1'b0, 8'hAA, 0, 0));
    send_byte(glyph_byte(1'b0, 8'h81, 0, 0));
    send_byte(glyph_byte(1'b1, 8'h55, 2047, 2047));
    drain();

    write_reg(CFG_SPARE, 16'h5A5A);
    program_regs(1, 0, 0, 1, 16'h0000);
    send_byte(glyph_byte(1'b1, 8'h0F, 100, 2000));
    send_byte(glyph_byte(1'b0, 8'h5A, 0, 0));
    drain();

    program_regs(64, 8, 8, 0, 16'hF81F);
    send_byte(glyph_byte(1'b1, 8'hAA, 1600, 30));
    repeat (7) send_byte(glyph_byte(1'b0, 8'hAA, 0, 0));
    drain();

    program_regs(127, 15, 9, 0, 16'h07E0);
    send_byte(glyph_byte(1'b1, 8'hFF, 5, 5));
    repeat (7) send_byte(glyph_byte(1'b0, 8'hC3, 0, 0));
    drain();

    program_regs(12, 2, 3, 0, 16'h001F);
    send_byte(glyph_byte(1'b1, 8'hFF, 10, 10));
    drain();
    write_reg(CFG_ROW_WIDTH, 5);
    cfg_valid = 1'b0;
    send_byte(glyph_byte(1'b0, 8'h00, 0, 0));
    drain();

    // drive the row counter into saturation
    program_regs(1, 1, 1, 0, $urandom_range(65535, 0));
    send_byte(glyph_byte(1'b1, BYTE_W'($urandom_range(255, 0)), pick_coord(), pick_coord()));
    repeat (39) send_byte(glyph_byte(1'b0, BYTE_W'($urandom_range(255, 0)), 0, 0));
    drain();
    total = 40;

    // hold the output off and keep offering items
    idle_on = 1'b0;
    program_regs(8, 1, 1, 0, $urandom_range(65535, 0));
    holds_asked++;
    send_glyph(48, 1'b1);
    drain();
    total += 48;

    while (total < 330) begin
      idle_on = ($urandom_range(3, 0) != 0);
      run_phase(40, sent);
      total += sent;
    end

    idle_on = 1'b0;
    run_phase(40, sent);

    if (board.errors == 0)
      $display("glyph_bitmap_run_rectangles_test: done, clean");
    else
      $display("glyph_bitmap_run_rectangles_test: done, errors");
    $finish;
  end

endmodule
